FILE: rtl/nlic_pkg.sv
// ----------------------------------------------------------------------------
// nlic_pkg: shared types and constants of the nested loop index counter
// Request codes, configuration register layout and fixed port widths.
// ----------------------------------------------------------------------------
package nlic_pkg;

  // Fixed widths of the request and result fields
  localparam int unsigned ReqWidth    = 3;
  localparam int unsigned SelWidth    = 2;
  localparam int unsigned PosWidth    = 16;
  localparam int unsigned CfgIdxWidth = 4;
  localparam int unsigned MaxDigits   = 4;

  // Configuration layout: register 2k is lower_bound_k, 2k+1 is upper_bound_k
  localparam logic CfgKindLower = 1'b0;
  localparam logic CfgKindUpper = 1'b1;

  // Request codes; the remaining codes change nothing
  typedef enum logic [ReqWidth-1:0] {
    REQ_INC     = 3'd0,
    REQ_DEC     = 3'd1,
    REQ_RESTART = 3'd2,
    REQ_END     = 3'd3,
    REQ_SET     = 3'd4
  } req_e;

endpackage

FILE: rtl/nested_loop_index_counter.sv
// ----------------------------------------------------------------------------
// nested_loop_index_counter: mixed-radix odometer for nested loop indices
// Steps NUM_DIGITS digit positions, each over [lower_bound, upper_bound).
// ----------------------------------------------------------------------------
// Usage
//   Request channel (in_valid_i / in_stall_o) carries req_type_i, digit_sel_i
//   and set_value_i. Each request yields exactly one result on the result
//   channel (out_valid_o / out_stall_i): pos_0_o..pos_3_o, at_end_o and
//   wrapped_o. Digits at or above NUM_DIGITS read as zero.
//   Bounds are written through cfg_valid_i / cfg_ready_o with cfg_index_i
//   (2k lower bound of digit k, 2k+1 upper bound) and cfg_data_i; indices of
//   eight and above are dropped. Write bounds only while no request is open.
// Timing
//   A request is captured in the request register, and its result is then
//   written to the result register once that register is free. One request
//   per cycle is sustained while the receiver does not stall; the carry and
//   borrow ripple across the digits between the registers sets the cycle time.
// Reset and stall
//   Reset empties both registers, puts every digit at zero and the bounds at
//   lower 0 / upper 16. While the receiver stalls, the result holds and the
//   request register takes one more request before in_stall_o rises.
// ----------------------------------------------------------------------------
module nested_loop_index_counter
  import nlic_pkg::*;
#(
  parameter int unsigned NUM_DIGITS  = 4,
  parameter int unsigned DIGIT_WIDTH = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // Configuration write channel
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CfgIdxWidth-1:0] cfg_index_i,
  input  logic [PosWidth-1:0]    cfg_data_i,
  // Request channel
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [ReqWidth-1:0]    req_type_i,
  input  logic [SelWidth-1:0]    digit_sel_i,
  input  logic [PosWidth-1:0]    set_value_i,
  // Result channel
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [PosWidth-1:0]    pos_0_o,
  output logic [PosWidth-1:0]    pos_1_o,
  output logic [PosWidth-1:0]    pos_2_o,
  output logic [PosWidth-1:0]    pos_3_o,
  output logic                   at_end_o,
  output logic                   wrapped_o
);

  localparam int unsigned Dw = DIGIT_WIDTH;
  localparam int unsigned Nd = NUM_DIGITS;
  localparam logic [Dw-1:0] UpperReset = Dw'(16);

  // Bounds and digit state
  logic [Dw-1:0] lower_q [Nd];
  logic [Dw-1:0] upper_q [Nd];
  logic [Dw-1:0] pos_q   [Nd];
  logic [Dw-1:0] pos_d   [Nd];

  // Request register
  logic                req_valid_q;
  logic [ReqWidth-1:0] req_type_q;
  logic [SelWidth-1:0] digit_sel_q;
  logic [Dw-1:0]       set_value_q;

  // Result register flags
  logic out_valid_q;
  logic at_end_q, at_end_d;
  logic wrapped_q, wrapped_d;

  logic out_ready;
  logic fire;

  // Handshake: result register frees when empty or taken this cycle
  assign out_ready   = ~out_valid_q | ~out_stall_i;
  assign fire        = req_valid_q & out_ready;
  assign in_stall_o  = req_valid_q & ~out_ready;
  assign cfg_ready_o = 1'b1;

  // Bound registers, one pair per active digit
  for (genvar k = 0; k < Nd; k++) begin : g_bounds
    logic cfg_hit;
    assign cfg_hit = cfg_valid_i && (cfg_index_i[CfgIdxWidth-1:1] == (CfgIdxWidth-1)'(k));

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        lower_q[k] <= '0;
        upper_q[k] <= UpperReset;
      end else if (cfg_hit) begin
        if (cfg_index_i[0] == CfgKindUpper) begin
          upper_q[k] <= Dw'(cfg_data_i);
        end else begin
          lower_q[k] <= Dw'(cfg_data_i);
        end
      end
    end
  end

  // Capture a request whenever the request register is free
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      req_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      req_type_q  <= req_type_i;
      digit_sel_q <= digit_sel_i;
      set_value_q <= Dw'(set_value_i);
    end
  end

  // Next digit positions: carry and borrow ripple from digit 0 upward
  always_comb begin
    logic [Nd:0]   carry_chain;
    logic [Nd:0]   borrow_chain;
    logic [Nd-1:0] at_upper;
    logic [Dw:0]   nxt;
    logic          cur_end;
    logic [Dw-1:0] inc_pos [Nd];
    logic [Dw-1:0] dec_pos [Nd];

    carry_chain[0]  = 1'b1;
    borrow_chain[0] = 1'b1;
    for (int k = 0; k < Nd; k++) begin
      nxt = {1'b0, pos_q[k]} + (Dw+1)'(1);
      at_upper[k] = (pos_q[k] == upper_q[k]);
      carry_chain[k+1]  = carry_chain[k] & (nxt >= {1'b0, upper_q[k]});
      borrow_chain[k+1] = borrow_chain[k] & (pos_q[k] <= lower_q[k]);
      if (!carry_chain[k]) begin
        inc_pos[k] = pos_q[k];
      end else if (carry_chain[k+1]) begin
        inc_pos[k] = lower_q[k];
      end else begin
        inc_pos[k] = nxt[Dw-1:0];
      end
      if (!borrow_chain[k]) begin
        dec_pos[k] = pos_q[k];
      end else if (borrow_chain[k+1]) begin
        dec_pos[k] = upper_q[k] - Dw'(1);
      end else begin
        dec_pos[k] = pos_q[k] - Dw'(1);
      end
    end
    cur_end = &at_upper;

    pos_d     = pos_q;
    wrapped_d = 1'b0;
    unique case (req_e'(req_type_q))
      REQ_INC: begin
        if (!cur_end) begin
          if (carry_chain[Nd]) begin
            pos_d     = upper_q;
            wrapped_d = 1'b1;
          end else begin
            pos_d = inc_pos;
          end
        end
      end
      REQ_DEC: begin
        if (cur_end) begin
          for (int k = 0; k < Nd; k++) begin
            pos_d[k] = upper_q[k] - Dw'(1);
          end
        end else if (borrow_chain[Nd]) begin
          pos_d     = upper_q;
          wrapped_d = 1'b1;
        end else begin
          pos_d = dec_pos;
        end
      end
      REQ_RESTART: pos_d = lower_q;
      REQ_END:     pos_d = upper_q;
      REQ_SET: begin
        for (int k = 0; k < Nd; k++) begin
          if ({1'b0, digit_sel_q} == (SelWidth+1)'(k)) begin
            if (lower_q[k] <= set_value_q && set_value_q < upper_q[k]) begin
              pos_d[k] = set_value_q;
            end else begin
              pos_d[k] = upper_q[k];
            end
          end
        end
      end
      default: pos_d = pos_q;
    endcase
  end

  // End flag of the new position
  always_comb begin
    logic [Nd-1:0] eq;
    for (int k = 0; k < Nd; k++) begin
      eq[k] = (pos_d[k] == upper_q[k]);
    end
    at_end_d = &eq;
  end

  // Result register: digit state doubles as the result payload
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      for (int k = 0; k < Nd; k++) begin
        pos_q[k] <= '0;
      end
    end else if (out_ready) begin
      out_valid_q <= req_valid_q;
      if (req_valid_q) begin
        pos_q <= pos_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      at_end_q  <= at_end_d;
      wrapped_q <= wrapped_d;
    end
  end

  // Drive result ports; inactive digits read zero
  logic [PosWidth-1:0] pos_out [MaxDigits];
  for (genvar k = 0; k < MaxDigits; k++) begin : g_out
    if (k < Nd) begin : g_active
      assign pos_out[k] = PosWidth'(pos_q[k]);
    end else begin : g_idle
      assign pos_out[k] = '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign pos_0_o     = pos_out[0];
  assign pos_1_o     = pos_out[1];
  assign pos_2_o     = pos_out[2];
  assign pos_3_o     = pos_out[3];
  assign at_end_o    = at_end_q;
  assign wrapped_o   = wrapped_q;

endmodule

FILE: rtl/nlic_checker.sv
// ----------------------------------------------------------------------------
// nlic_checker: port-level checks of the nested loop index counter
// Watches handshakes and result flags over time; bound to the top level.
// ----------------------------------------------------------------------------
module nlic_checker
  import nlic_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_valid_i,
  input logic                   in_stall_o,
  input logic                   out_valid_o,
  input logic                   out_stall_i,
  input logic [PosWidth-1:0]    pos_0_o,
  input logic [PosWidth-1:0]    pos_1_o,
  input logic [PosWidth-1:0]    pos_2_o,
  input logic [PosWidth-1:0]    pos_3_o,
  input logic                   at_end_o,
  input logic                   wrapped_o
);

  // Hold a stalled result unchanged
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(pos_0_o) && $stable(pos_1_o)
      && $stable(pos_2_o) && $stable(pos_3_o) && $stable(at_end_o) && $stable(wrapped_o))
    else $error("stalled result changed");

  // A carry or borrow out of the top digit lands on the end position
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && wrapped_o |-> at_end_o)
    else $error("wrapped result not at end");

  // Never stall requests while the result register is empty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("request stalled with empty result register");

  // A request accepted into the request register is followed by a valid result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |-> ##2 out_valid_o)
    else $error("request lost between request and result registers");

endmodule

bind nested_loop_index_counter nlic_checker u_nlic_checker (.*);
